FILE: hdl/mdps_pkg.sv
// ----------------------------------------------------------------------------
// mdps_pkg
// Shared constants and types of the minimum point-set distance unit.
// ----------------------------------------------------------------------------
package mdps_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int COORD_BITS = 24;

   localparam int ADDR_BITS  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int SQ_BITS    = 2 * COORD_BITS + 1;
   localparam int SUM_BITS   = 2 * COORD_BITS + 2;
   localparam int ROOT_BITS  = SUM_BITS / 2;
   localparam int REM_BITS   = ROOT_BITS + 2;
   localparam int STEP_BITS  = $clog2(ROOT_BITS);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } point_type;

   localparam int POINT_BITS = $bits(point_type);

   typedef struct packed {
      logic valid;
      logic last;
   } pipe_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } root_status_type;

endpackage

FILE: hdl/min_distance_between_point_sets_unit.sv
// ----------------------------------------------------------------------------
// min_distance_between_point_sets_unit
// Least Euclidean distance between two loaded 3D point sets.
//
// Requests (req_*) load one point per cycle while req_ready is high;
// req_mode picks the store. A request with req_mode = 1 and
// req_final_point = 1 ends loading and starts the search; req_no_point = 1
// stores nothing. During the search req_ready is low. Every pair is scanned
// at one pair per cycle from the two point RAMs, then passes the RAM read
// and the distance pipeline; the least squared distance goes through the
// bit-serial square root before hand-over. With an empty set the scan and
// the square root are skipped. The result waits in the output register
// while rsp_ready is low; loading of the next sets proceeds meanwhile, and
// a following search holds its result until the register is free. Point
// counts and the overflow flag clear when the result is handed over. Reset
// clears all control state; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module min_distance_between_point_sets_unit import mdps_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_mode,
   input  logic signed [COORD_BITS-1:0] req_x_pos,
   input  logic signed [COORD_BITS-1:0] req_y_pos,
   input  logic signed [COORD_BITS-1:0] req_z_pos,
   input  logic                         req_final_point,
   input  logic                         req_no_point,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ROOT_BITS-1:0]         rsp_min_distance,
   output logic                         rsp_empty_set,
   output logic                         rsp_overflow
);

   localparam logic [2:0] ST_LOAD    = 3'd0;
   localparam logic [2:0] ST_SCAN    = 3'd1;
   localparam logic [2:0] ST_DRAIN   = 3'd2;
   localparam logic [2:0] ST_ROOT_GO = 3'd3;
   localparam logic [2:0] ST_ROOT    = 3'd4;
   localparam logic [2:0] ST_DONE    = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic                 drop_ff, drop_in;
   logic [ADDR_BITS-1:0] i_ff, i_in, j_ff, j_in;
   logic [SUM_BITS-1:0]  min_ff, min_in;
   logic [ROOT_BITS-1:0] res_dist_ff, res_dist_in;
   logic                 res_empty_ff, res_empty_in, res_ovf_ff, res_ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ROOT_BITS-1:0] rsp_dist_ff, rsp_dist_in;
   logic                 rsp_empty_ff, rsp_empty_in, rsp_ovf_ff, rsp_ovf_in;
   pipe_ctrl_type        rd_ctrl_ff, rd_ctrl_in;

   logic                 req_accept, out_free;
   logic                 wa_en, wb_en, rd_en, last_i, last_j, root_start;
   point_type            wr_point, pt_a, pt_b;
   pipe_ctrl_type        sum_ctrl;
   logic [SUM_BITS-1:0]  sum;
   root_status_type      root_status;
   logic [ROOT_BITS-1:0] root;

   assign req_ready  = (state_ff == ST_LOAD);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign wr_point   = '{x: req_x_pos, y: req_y_pos, z: req_z_pos};
   assign last_i     = (CNT_BITS'(i_ff) + CNT_BITS'(1)) == cnt_a_ff;
   assign last_j     = (CNT_BITS'(j_ff) + CNT_BITS'(1)) == cnt_b_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      drop_in      = drop_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      min_in       = min_ff;
      res_dist_in  = res_dist_ff;
      res_empty_in = res_empty_ff;
      res_ovf_in   = res_ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rd_ctrl_in   = '0;
      wa_en        = 1'b0;
      wb_en        = 1'b0;
      rd_en        = 1'b0;
      root_start   = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (sum_ctrl.valid && (sum < min_ff)) begin
         min_in = sum;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (!req_no_point) begin
                  if (!req_mode) begin
                     if (cnt_a_ff != CNT_BITS'(MAX_POINTS)) begin
                        wa_en    = 1'b1;
                        cnt_a_in = cnt_a_ff + CNT_BITS'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end else begin
                     if (cnt_b_ff != CNT_BITS'(MAX_POINTS)) begin
                        wb_en    = 1'b1;
                        cnt_b_in = cnt_b_ff + CNT_BITS'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
               end
               if (req_final_point && req_mode) begin
                  i_in       = '0;
                  j_in       = '0;
                  min_in     = '1;
                  res_ovf_in = drop_in;
                  if ((cnt_a_in == '0) || (cnt_b_in == '0)) begin
                     res_dist_in  = '0;
                     res_empty_in = 1'b1;
                     state_in     = ST_DONE;
                  end else begin
                     res_empty_in = 1'b0;
                     state_in     = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            rd_en            = 1'b1;
            rd_ctrl_in.valid = 1'b1;
            rd_ctrl_in.last  = last_i && last_j;
            if (last_j) begin
               j_in = '0;
               if (last_i) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + ADDR_BITS'(1);
               end
            end else begin
               j_in = j_ff + ADDR_BITS'(1);
            end
         end
         ST_DRAIN: begin
            if (sum_ctrl.valid && sum_ctrl.last) begin
               state_in = ST_ROOT_GO;
            end
         end
         ST_ROOT_GO: begin
            root_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_status.done) begin
               res_dist_in = root;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = res_dist_ff;
               rsp_empty_in = res_empty_ff;
               rsp_ovf_in   = res_ovf_ff;
               cnt_a_in     = '0;
               cnt_b_in     = '0;
               drop_in      = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_ctrl_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_ctrl_ff   <= rd_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      min_ff       <= min_in;
      res_dist_ff  <= res_dist_in;
      res_empty_ff <= res_empty_in;
      res_ovf_ff   <= res_ovf_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   mdps_ram #(.DEPTH(MAX_POINTS), .WIDTH(POINT_BITS)) u_store_a (
      .clock   (clock),
      .wr_en   (wa_en),
      .wr_addr (cnt_a_ff[ADDR_BITS-1:0]),
      .wr_data (wr_point),
      .rd_en   (rd_en),
      .rd_addr (i_ff),
      .rd_data (pt_a)
   );

   mdps_ram #(.DEPTH(MAX_POINTS), .WIDTH(POINT_BITS)) u_store_b (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (cnt_b_ff[ADDR_BITS-1:0]),
      .wr_data (wr_point),
      .rd_en   (rd_en),
      .rd_addr (j_ff),
      .rd_data (pt_b)
   );

   mdps_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_ctrl  (rd_ctrl_ff),
      .pt_a     (pt_a),
      .pt_b     (pt_b),
      .out_ctrl (sum_ctrl),
      .sum      (sum)
   );

   mdps_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (root_start),
      .value  (min_ff),
      .status (root_status),
      .root   (root)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_min_distance = rsp_dist_ff;
   assign rsp_empty_set    = rsp_empty_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   // scan reads only entries below the fill counts
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |->
         ((CNT_BITS'(i_ff) < cnt_a_ff) && (CNT_BITS'(j_ff) < cnt_b_ff)))
      else $error("scan index beyond fill count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_a_ff <= CNT_BITS'(MAX_POINTS)) && (cnt_b_ff <= CNT_BITS'(MAX_POINTS)))
      else $error("fill count beyond store depth");

   a_root_start_idle: assert property (@(posedge clock) disable iff (reset)
      root_start |-> !root_status.busy)
      else $error("square root restarted while busy");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_set) |-> (rsp_min_distance == '0))
      else $error("empty result with non-zero distance");

endmodule

FILE: hdl/mdps_ram.sv
// ----------------------------------------------------------------------------
// mdps_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mdps_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 72
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/mdps_dist.sv
// ----------------------------------------------------------------------------
// mdps_dist
// Three-stage pipeline: absolute differences, squares, squared distance.
// ----------------------------------------------------------------------------
module mdps_dist import mdps_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  pipe_ctrl_type       in_ctrl,
   input  point_type           pt_a,
   input  point_type           pt_b,
   output pipe_ctrl_type       out_ctrl,
   output logic [SUM_BITS-1:0] sum
);

   pipe_ctrl_type       ctrl1_ff, ctrl2_ff, ctrl3_ff;
   logic [DIFF_BITS-1:0] adx_in, ady_in, adz_in;
   logic [DIFF_BITS-1:0] adx_ff, ady_ff, adz_ff;
   logic [SQ_BITS-1:0]   sqx_ff, sqy_ff, sqz_ff;
   logic [SUM_BITS-1:0]  sum_ff;

   function automatic logic [DIFF_BITS-1:0] abs_diff(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      logic signed [DIFF_BITS-1:0] d;
      d = DIFF_BITS'(a) - DIFF_BITS'(b);
      return d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
   endfunction

   always_comb begin
      adx_in = abs_diff(pt_a.x, pt_b.x);
      ady_in = abs_diff(pt_a.y, pt_b.y);
      adz_in = abs_diff(pt_a.z, pt_b.z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff <= '0;
         ctrl2_ff <= '0;
         ctrl3_ff <= '0;
      end else begin
         ctrl1_ff <= in_ctrl;
         ctrl2_ff <= ctrl1_ff;
         ctrl3_ff <= ctrl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      adx_ff <= adx_in;
      ady_ff <= ady_in;
      adz_ff <= adz_in;
      sqx_ff <= SQ_BITS'(adx_ff * adx_ff);
      sqy_ff <= SQ_BITS'(ady_ff * ady_ff);
      sqz_ff <= SQ_BITS'(adz_ff * adz_ff);
      sum_ff <= SUM_BITS'(sqx_ff) + SUM_BITS'(sqy_ff) + SUM_BITS'(sqz_ff);
   end

   assign out_ctrl = ctrl3_ff;
   assign sum      = sum_ff;

endmodule

FILE: hdl/mdps_isqrt.sv
// ----------------------------------------------------------------------------
// mdps_isqrt
// Floor square root, restoring method, one result bit per cycle.
// ----------------------------------------------------------------------------
module mdps_isqrt import mdps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SUM_BITS-1:0]  value,
   output root_status_type      status,
   output logic [ROOT_BITS-1:0] root
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [SUM_BITS-1:0]  val_ff, val_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [REM_BITS-1:0]  rem_sh;
   logic [REM_BITS-1:0]  trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff[REM_BITS-3:0], val_ff[SUM_BITS-1 -: 2]};
      trial   = {root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_BITS'(ROOT_BITS - 1);
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in = {val_ff[SUM_BITS-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
         step_in = step_ff - STEP_BITS'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks min_distance_between_point_sets_unit with a directed table of point
// sets, then random sets of varied size and spread, including one store
// overflowing. Each request updates a local copy of the two point sets; a
// search request yields the expected distance, empty and overflow flags,
// which are matched in order against the results under random stalls.
// ----------------------------------------------------------------------------
module testbench import mdps_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic FIRST_SET  = 1'b0;
   localparam logic SECOND_SET = 1'b1;

   localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam longint unsigned DIST_LIMIT = (64'd1 << ROOT_BITS) - 1;

   localparam int REQUEST_TARGET = 1600;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct packed {
      logic [ROOT_BITS-1:0] distance;
      logic                 empty;
      logic                 overflow;
   } distance_result_type;

   typedef struct packed {
      logic                         mode;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic                         fin;
      logic                         nop;
      logic                         typed;
      logic [ROOT_BITS-1:0]         distance;
      logic                         empty;
      logic                         overflow;
   } stim_row_type;

   localparam int NUM_DIRECTED = 25;
   localparam stim_row_type DIRECTED [NUM_DIRECTED] = '{
      '{SECOND_SET, 0, 0, 0, 1, 1, 1, 0, 1, 0},
      '{FIRST_SET, 5, 6, 7, 0, 0, 0, 0, 0, 0},
      '{SECOND_SET, 0, 0, 0, 1, 1, 1, 0, 1, 0},
      '{SECOND_SET, 1, 2, 3, 0, 0, 0, 0, 0, 0},
      '{FIRST_SET, 0, 0, 0, 1, 1, 0, 0, 0, 0},
      '{SECOND_SET, 0, 0, 0, 1, 1, 1, 0, 1, 0},
      '{FIRST_SET, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0, 0, 0},
      '{SECOND_SET, C_MIN, C_MIN, C_MIN, 1, 0, 0, 0, 0, 0},
      '{FIRST_SET, C_MIN, C_MAX, 0, 0, 0, 0, 0, 0, 0},
      '{SECOND_SET, C_MIN, C_MAX, 0, 1, 0, 1, 0, 0, 0},
      '{FIRST_SET, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{SECOND_SET, 3, 4, 0, 1, 0, 1, 5, 0, 0},
      '{FIRST_SET, 10, 0, 0, 1, 0, 0, 0, 0, 0},
      '{SECOND_SET, 0, 0, 0, 1, 0, 1, 10, 0, 0},
      '{FIRST_SET, -1, -1, -1, 0, 0, 0, 0, 0, 0},
      '{SECOND_SET, 0, 0, 0, 0, 1, 0, 0, 0, 0},
      '{FIRST_SET, 0, 0, 0, 0, 1, 0, 0, 0, 0},
      '{SECOND_SET, -1, -1, -1, 0, 0, 0, 0, 0, 0},
      '{SECOND_SET, 0, 0, 0, 1, 1, 1, 0, 0, 0},
      '{FIRST_SET, 100, 0, 0, 0, 0, 0, 0, 0, 0},
      '{FIRST_SET, 0, 100, 0, 0, 0, 0, 0, 0, 0},
      '{FIRST_SET, -40, -40, -40, 0, 0, 0, 0, 0, 0},
      '{SECOND_SET, 0, 0, -7, 0, 0, 0, 0, 0, 0},
      '{SECOND_SET, 90, 1, 2, 0, 0, 0, 0, 0, 0},
      '{SECOND_SET, 0, 0, 0, 1, 1, 0, 0, 0, 0}
   };

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_mode = FIRST_SET;
   logic signed [COORD_BITS-1:0] req_x_pos = '0;
   logic signed [COORD_BITS-1:0] req_y_pos = '0;
   logic signed [COORD_BITS-1:0] req_z_pos = '0;
   logic                         req_final_point = 1'b0;
   logic                         req_no_point = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [ROOT_BITS-1:0]         rsp_min_distance;
   logic                         rsp_empty_set;
   logic                         rsp_overflow;

   point_type           first_points[$];
   point_type           second_points[$];
   bit                  points_dropped = 1'b0;
   distance_result_type expected_results[$];

   int fail_count     = 0;
   int accepted_count = 0;
   int cycle_count    = 0;
   int req_steady     = 0;
   int rsp_steady     = 0;
   int rsp_hold       = 0;

   min_distance_between_point_sets_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .req_z_pos        (req_z_pos),
      .req_final_point  (req_final_point),
      .req_no_point     (req_no_point),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_min_distance (rsp_min_distance),
      .rsp_empty_set    (rsp_empty_set),
      .rsp_overflow     (rsp_overflow)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** min_distance_between_point_sets_unit: FAILED **");
         $finish;
      end
   end

   // mostly short gaps, a few long ones, with runs of back-to-back traffic
   function automatic int idle_len(inout int steady);
      int r;
      if (steady > 0) begin
         steady--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         steady = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic void apply_request(input logic mode, input point_type pt,
                                         input logic fin, input logic nop,
                                         output bit gives,
                                         output distance_result_type res);
      longint unsigned least;
      longint unsigned sum;
      longint unsigned root;
      longint signed   dx;
      longint signed   dy;
      longint signed   dz;
      gives = 1'b0;
      res   = '0;
      if (!nop) begin
         if (mode == FIRST_SET) begin
            if (first_points.size() < MAX_POINTS)
               first_points.insert(first_points.size(), pt);
            else points_dropped = 1'b1;
         end else begin
            if (second_points.size() < MAX_POINTS)
               second_points.insert(second_points.size(), pt);
            else points_dropped = 1'b1;
         end
      end
      if (!(fin && mode == SECOND_SET)) return;
      gives = 1'b1;
      least = '1;
      foreach (first_points[i]) begin
         foreach (second_points[j]) begin
            dx  = longint'($signed(first_points[i].x)) - longint'($signed(second_points[j].x));
            dy  = longint'($signed(first_points[i].y)) - longint'($signed(second_points[j].y));
            dz  = longint'($signed(first_points[i].z)) - longint'($signed(second_points[j].z));
            sum = dx * dx + dy * dy + dz * dz;
            if (sum < least) least = sum;
         end
      end
      if (first_points.size() == 0 || second_points.size() == 0) begin
         res.empty = 1'b1;
      end else begin
         root = floor_root(least);
         if (root > DIST_LIMIT) root = DIST_LIMIT;
         res.distance = root[ROOT_BITS-1:0];
      end
      res.overflow = points_dropped;
      first_points.delete();
      second_points.delete();
      points_dropped = 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      fail_count++;
   endtask

   task automatic check_result();
      distance_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("unrequested result, distance", rsp_min_distance, 0);
         return;
      end
      want = expected_results.pop_front();
      if (rsp_min_distance !== want.distance)
         report_mismatch("min_distance", rsp_min_distance, want.distance);
      if (rsp_empty_set !== want.empty)
         report_mismatch("empty_set", rsp_empty_set, want.empty);
      if (rsp_overflow !== want.overflow)
         report_mismatch("overflow", rsp_overflow, want.overflow);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold  <= rsp_hold - 1;
         end else begin
            rsp_ready <= 1'b1;
            rsp_hold  <= idle_len(rsp_steady);
         end
      end
   end

   // called at a rising edge; returns at the edge the request is taken
   task automatic send_request(input logic mode, input point_type pt, input logic fin,
                               input logic nop, input bit typed,
                               input distance_result_type typed_res);
      int                  gap;
      bit                  gives;
      distance_result_type res;
      gap = idle_len(req_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_x_pos       <= pt.x;
      req_y_pos       <= pt.y;
      req_z_pos       <= pt.z;
      req_final_point <= fin;
      req_no_point    <= nop;
      do @(posedge clock); while (!req_ready);
      apply_request(mode, pt, fin, nop, gives, res);
      if (gives) expected_results.insert(expected_results.size(), typed ? typed_res : res);
      accepted_count++;
   endtask

   function automatic point_type random_point(input point_type centre, input int spread);
      point_type p;
      if (spread == 0) begin
         p.x = COORD_BITS'($urandom);
         p.y = COORD_BITS'($urandom);
         p.z = COORD_BITS'($urandom);
      end else begin
         p.x = centre.x + COORD_BITS'($urandom_range(0, 2 * spread)) - COORD_BITS'(spread);
         p.y = centre.y + COORD_BITS'($urandom_range(0, 2 * spread)) - COORD_BITS'(spread);
         p.z = centre.z + COORD_BITS'($urandom_range(0, 2 * spread)) - COORD_BITS'(spread);
      end
      return p;
   endfunction

   // one load of both sets in random order, closed by a search request
   task automatic send_sets(input int n_first, input int n_second, input bit noisy);
      int        left_first;
      int        left_second;
      int        spread;
      int        r;
      bit        closing_point;
      point_type centre;
      r = $urandom_range(0, 2);
      spread = (r == 0) ? 0 : (r == 1) ? 8 : 2000;
      centre.x = COORD_BITS'($urandom);
      centre.y = COORD_BITS'($urandom);
      centre.z = COORD_BITS'($urandom);
      closing_point = (n_second > 0) && ($urandom_range(0, 1) == 1);
      left_first  = n_first;
      left_second = closing_point ? n_second - 1 : n_second;
      while (left_first + left_second > 0) begin
         if (noisy && $urandom_range(0, 9) == 0)
            send_request(1'($urandom_range(0, 1)), random_point(centre, 0), 1'b0, 1'b1,
                         1'b0, '0);
         if (left_first > 0 && (left_second == 0 || $urandom_range(0, 1) == 1)) begin
            send_request(FIRST_SET, random_point(centre, spread),
                         $urandom_range(0, 7) == 0, 1'b0, 1'b0, '0);
            left_first--;
         end else begin
            send_request(SECOND_SET, random_point(centre, spread), 1'b0, 1'b0, 1'b0, '0);
            left_second--;
         end
      end
      if (noisy && $urandom_range(0, 3) == 0)
         send_request(FIRST_SET, random_point(centre, 0), 1'b1, 1'b1, 1'b0, '0);
      send_request(SECOND_SET, random_point(centre, spread), 1'b1, !closing_point, 1'b0, '0);
   endtask

   initial begin
      stim_row_type        row;
      point_type           pt;
      distance_result_type typed_res;
      int                  kind;
      bit                  full_done;
      full_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         row       = DIRECTED[i];
         pt.x      = row.x;
         pt.y      = row.y;
         pt.z      = row.z;
         typed_res.distance = row.distance;
         typed_res.empty    = row.empty;
         typed_res.overflow = row.overflow;
         send_request(row.mode, pt, row.fin, row.nop, row.typed, typed_res);
      end

      while (accepted_count < REQUEST_TARGET) begin
         kind = $urandom_range(0, 99);
         if (!full_done && accepted_count > 300) begin
            if ($urandom_range(0, 1) == 1)
               send_sets(MAX_POINTS + $urandom_range(1, 3), $urandom_range(1, 2), 1'b0);
            else
               send_sets($urandom_range(1, 2), MAX_POINTS + $urandom_range(1, 3), 1'b0);
            full_done = 1'b1;
         end else if (kind < 72) begin
            send_sets($urandom_range(1, 6), $urandom_range(1, 6), kind < 20);
         end else if (kind < 80) begin
            send_sets($urandom_range(8, 32), $urandom_range(8, 32), 1'b0);
         end else if (kind < 88) begin
            case ($urandom_range(0, 2))
               0: send_sets(0, $urandom_range(1, 4), 1'b1);
               1: send_sets($urandom_range(1, 4), 0, 1'b1);
               default: send_sets(0, 0, 1'b0);
            endcase
         end else begin
            // broken sequence: stray marks and empty requests before a search
            pt = random_point('0, 0);
            send_request(1'($urandom_range(0, 1)), pt, 1'b0, 1'b1, 1'b0, '0);
            send_request(FIRST_SET, pt, 1'b1, 1'($urandom_range(0, 1)), 1'b0, '0);
            send_sets($urandom_range(0, 3), $urandom_range(0, 3), 1'b1);
         end
      end
      req_valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("** min_distance_between_point_sets_unit: PASSED **");
      end else begin
         $display("** min_distance_between_point_sets_unit: FAILED **");
      end
      $finish;
   end

endmodule
